// ----- rtl/stru_pkg.sv -----
package stru_pkg;

  // Fixed-point format of rates and times
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int TIME_W   = 48;
  localparam int BETA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int TSCALE_W = 24;
  localparam int RATE_W   = 32;
  localparam int AMP_W    = 17;
  localparam int FACTOR_W = 18;
  localparam int DAY_W    = 9;
  localparam int USER_W   = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE   = 3'd0,
    REG_PERIOD = 3'd1,
    REG_TSCALE = 3'd2,
    REG_BASE   = 3'd3,
    REG_AMP    = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INVALID = 2'd0,
    MODE_SINE    = 2'd1,
    MODE_MULT    = 2'd2,
    MODE_ADD     = 2'd3
  } mode_t;

  // Reset values of the registers
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd23920640;
  localparam logic [TSCALE_W-1:0] TSCALE_RST = 24'd65536;
  localparam logic [RATE_W-1:0]   BASE_RST   = 32'd65536;

  // One in the rate format, wide enough for 1 + amplitude
  localparam logic [FACTOR_W-1:0] FX_ONE = FACTOR_W'(1 << FRAC_BITS);

  // Sine arithmetic in unsigned Q1.30
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Taylor divisors, innermost term first, and floor(2^32 / divisor)
  localparam int TAYLOR_N = 6;
  localparam logic [7:0] TAYLOR_DIV [TAYLOR_N] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] TAYLOR_RECIP [TAYLOR_N] = '{
    30'(64'h1_0000_0000 / 64'd156), 30'(64'h1_0000_0000 / 64'd110),
    30'(64'h1_0000_0000 / 64'd72),  30'(64'h1_0000_0000 / 64'd42),
    30'(64'h1_0000_0000 / 64'd20),  30'(64'h1_0000_0000 / 64'd6)
  };

  // School calendar
  localparam logic [DAY_W-1:0] DAYS_PER_YEAR = 9'd365;

  function automatic logic is_term_day(input logic [DAY_W-1:0] day);
    return !(day inside {[9'd1:9'd6], [9'd100:9'd115], [9'd200:9'd251],
                         [9'd300:9'd307], [9'd356:9'd365]});
  endfunction

endpackage

// ----- rtl/seasonal_transmission_rate_unit.sv -----
// Throughput: one time value per cycle while the output register is not stalled; a pipeline
//   of 107 register stages, most of them the 48 remainder steps and 32 phase quotient steps
//   of the bit-serial divider stages.
// Stall: the whole pipeline holds while the output register is full and not taken.
// Reset: synchronous, clears all valid bits and loads the default register values.
module seasonal_transmission_rate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [stru_pkg::TIME_W-1:0]    s_axis_tdata,   // [47:0] time_now
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [stru_pkg::BETA_W-1:0]    m_axis_tdata,   // [31:0] beta
  output logic [stru_pkg::USER_W-1:0]    m_axis_tuser,   // [0] in_term, [1] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stru_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [stru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stru_pkg::*;

  // Stage map
  localparam int ST_MOD_END = TIME_W;            // t mod period, t mod 365*scale
  localparam int ST_PH0     = ST_MOD_END + 1;    // first phase / holiday quotient step
  localparam int ST_PH_END  = ST_MOD_END + 32;
  localparam int ST_DAY_END = ST_MOD_END + DAY_W;
  localparam int ST_TERM    = ST_DAY_END + 1;
  localparam int ST_QUAD    = ST_PH_END + 1;
  localparam int ST_Y       = ST_QUAD + 1;
  localparam int ST_Z       = ST_Y + 1;
  localparam int ST_IT0     = ST_Z + 1;
  localparam int ST_H_END   = ST_IT0 + 3 * TAYLOR_N - 1;
  localparam int ST_S       = ST_H_END + 1;
  localparam int ST_M       = ST_S + 1;
  localparam int ST_F       = ST_M + 1;
  localparam int ST_P       = ST_F + 1;
  localparam int ST_OUT     = ST_P + 1;

  // Configuration registers
  mode_t                mode;
  logic [PERIOD_W-1:0]  period;
  logic [TSCALE_W-1:0]  time_scale;
  logic [RATE_W-1:0]    base_rate;
  logic [AMP_W-1:0]     amplitude;

  // Values derived from configuration
  logic [TSCALE_W-1:0]  ts_eff;
  logic [32:0]          year_len;
  logic [FACTOR_W-1:0]  hol_div;

  // Pipeline control
  logic                 en;
  logic                 v [0:ST_OUT];

  // Divider stages
  logic [TIME_W-1:0]    tq [0:ST_MOD_END-1];
  logic [31:0]          rs [1:ST_PH_END];
  logic [32:0]          rd [1:ST_DAY_END];
  logic [31:0]          ph [ST_PH0:ST_PH_END];
  logic [DAY_W-1:0]     dq [ST_PH0:ST_DAY_END];
  logic [TIME_W-1:0]    hr [ST_PH0:ST_PH_END];
  logic [31:0]          hq [ST_PH0:ST_P];
  logic                 tm [ST_TERM:ST_P];

  // Sine stages
  logic [1:0]           qd [ST_QUAD:ST_M];
  logic [30:0]          qa;
  logic [30:0]          ya [ST_Y:ST_H_END];
  logic [31:0]          za [ST_Z:ST_H_END-3];
  logic [31:0]          xa [TAYLOR_N];
  logic [31:0]          xb [TAYLOR_N];
  logic [29:0]          q0 [TAYLOR_N];
  logic [30:0]          hn [TAYLOR_N];
  logic [30:0]          hin [TAYLOR_N];
  logic [30:0]          sa;
  logic [AMP_W-1:0]     ma;
  logic [FACTOR_W-1:0]  fa;
  logic [RATE_W+FACTOR_W-1:0] pa;

  // Output register
  logic [BETA_W-1:0]    out_beta;
  logic                 out_term;
  logic                 out_status;

  // One remainder step against a 32-bit divisor
  function automatic logic [31:0] mod_step32(input logic [31:0] r, input logic b,
                                             input logic [31:0] d);
    logic [32:0] r2;
    r2 = {r, b};
    if (r2 >= {1'b0, d}) return 32'(r2 - {1'b0, d});
    return r2[31:0];
  endfunction

  // One remainder step against a 33-bit divisor
  function automatic logic [32:0] mod_step33(input logic [32:0] r, input logic b,
                                             input logic [32:0] d);
    logic [33:0] r2;
    r2 = {r, b};
    if (r2 >= {1'b0, d}) return 33'(r2 - {1'b0, d});
    return r2[32:0];
  endfunction

  // One fraction bit of rem / period: {bit, new remainder}
  function automatic logic [32:0] ph_step(input logic [31:0] r, input logic [31:0] d);
    logic [32:0] r2;
    r2 = {r, 1'b0};
    if (r2 >= {1'b0, d}) return {1'b1, 32'(r2 - {1'b0, d})};
    return {1'b0, r2[31:0]};
  endfunction

  // One quotient bit of remainder / time_scale at weight 2^j
  function automatic logic [33:0] day_step(input logic [32:0] r, input logic [TSCALE_W-1:0] d,
                                           input int j);
    logic [32:0] sub;
    sub = 33'(d) << j;
    if (r >= sub) return {1'b1, r - sub};
    return {1'b0, r};
  endfunction

  // One quotient bit of the holiday division at weight 2^j
  function automatic logic [TIME_W:0] hol_step(input logic [TIME_W-1:0] r,
                                               input logic [FACTOR_W-1:0] d, input int j);
    logic [TIME_W:0] sub;
    sub = (TIME_W+1)'(d) << j;
    if ({1'b0, r} >= sub) return {1'b1, TIME_W'({1'b0, r} - sub)};
    return {1'b0, r};
  endfunction

  // Q2.30 product, truncated
  function automatic logic [31:0] q30_mul(input logic [31:0] a, input logic [30:0] b);
    logic [62:0] p;
    p = a * b;
    return 32'(p >> 30);
  endfunction

  // Correct the reciprocal estimate and form 1 - x/d
  function automatic logic [30:0] taylor_fix(input logic [31:0] x, input logic [29:0] est,
                                             input logic [7:0] d);
    logic [37:0] back;
    logic [38:0] rem;
    logic [30:0] q;
    back = est * d;
    rem  = {7'd0, x} - {1'b0, back};
    q    = (rem >= 39'(d)) ? 31'(est) + 31'd1 : 31'(est);
    return Q30_ONE - q;
  endfunction

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SINE;
      period     <= PERIOD_RST;
      time_scale <= TSCALE_RST;
      base_rate  <= BASE_RST;
      amplitude  <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_addr))
        REG_MODE:   mode       <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_PERIOD: period     <= cfg_data[PERIOD_W-1:0];
        REG_TSCALE: time_scale <= cfg_data[TSCALE_W-1:0];
        REG_BASE:   base_rate  <= cfg_data[RATE_W-1:0];
        REG_AMP:    amplitude  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derive divisors from configuration
  always_ff @(posedge clk) begin
    ts_eff   <= (time_scale == '0) ? TSCALE_W'(1) : time_scale;
    year_len <= 33'(ts_eff) * 33'(DAYS_PER_YEAR);
    hol_div  <= FX_ONE + FACTOR_W'(amplitude);
  end

  // Advance the whole pipeline unless the output register is stalled
  assign en            = !v[ST_OUT] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ST_OUT; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid;
      for (int k = 1; k <= ST_OUT; k++) v[k] <= v[k-1];
    end
  end

  // Remainder, phase, day and holiday quotient stages
  always_ff @(posedge clk) begin
    logic [32:0]     pstep;
    logic [33:0]     dstep;
    logic [TIME_W:0] hstep;
    if (en) begin
      tq[0] <= s_axis_tdata;
      for (int k = 1; k < ST_MOD_END; k++) tq[k] <= tq[k-1] << 1;

      rs[1] <= mod_step32(32'd0, tq[0][TIME_W-1], period);
      rd[1] <= mod_step33(33'd0, tq[0][TIME_W-1], year_len);
      for (int k = 2; k <= ST_MOD_END; k++) begin
        rs[k] <= mod_step32(rs[k-1], tq[k-1][TIME_W-1], period);
        rd[k] <= mod_step33(rd[k-1], tq[k-1][TIME_W-1], year_len);
      end

      pstep = ph_step(rs[ST_MOD_END], period);
      rs[ST_PH0] <= pstep[31:0];
      ph[ST_PH0] <= {31'd0, pstep[32]};
      for (int k = ST_PH0 + 1; k <= ST_PH_END; k++) begin
        pstep = ph_step(rs[k-1], period);
        rs[k] <= pstep[31:0];
        ph[k] <= {ph[k-1][30:0], pstep[32]};
      end

      dstep = day_step(rd[ST_MOD_END], ts_eff, DAY_W - 1);
      rd[ST_PH0] <= dstep[32:0];
      dq[ST_PH0] <= {{(DAY_W-1){1'b0}}, dstep[33]};
      for (int k = ST_PH0 + 1; k <= ST_DAY_END; k++) begin
        dstep = day_step(rd[k-1], ts_eff, ST_DAY_END - k);
        rd[k] <= dstep[32:0];
        dq[k] <= {dq[k-1][DAY_W-2:0], dstep[33]};
      end

      hstep = hol_step({base_rate, {FRAC_BITS{1'b0}}}, hol_div, 31);
      hr[ST_PH0] <= hstep[TIME_W-1:0];
      hq[ST_PH0] <= {31'd0, hstep[TIME_W]};
      for (int k = ST_PH0 + 1; k <= ST_PH_END; k++) begin
        hstep = hol_step(hr[k-1], hol_div, ST_PH_END - k);
        hr[k] <= hstep[TIME_W-1:0];
        hq[k] <= {hq[k-1][30:0], hstep[TIME_W]};
      end
      for (int k = ST_PH_END + 1; k <= ST_P; k++) hq[k] <= hq[k-1];

      // Calendar flag
      tm[ST_TERM] <= is_term_day(dq[ST_DAY_END]);
      for (int k = ST_TERM + 1; k <= ST_P; k++) tm[k] <= tm[k-1];
    end
  end

  // Running Taylor term into each iteration
  always_comb begin
    hin[0] = Q30_ONE;
    for (int i = 1; i < TAYLOR_N; i++) hin[i] = hn[i-1];
  end

  // Quarter-wave sine and forcing factor
  always_ff @(posedge clk) begin
    logic [62:0]          sprod;
    logic [47:0]          mprod;
    logic [31:0]          s_full;
    logic [FACTOR_W-1:0]  f;
    if (en) begin
      qd[ST_QUAD] <= ph[ST_PH_END][31:30];
      qa <= ph[ST_PH_END][30] ? Q30_ONE - {1'b0, ph[ST_PH_END][29:0]}
                              : {1'b0, ph[ST_PH_END][29:0]};
      for (int k = ST_QUAD + 1; k <= ST_M; k++) qd[k] <= qd[k-1];

      ya[ST_Y] <= 31'(q30_mul({1'b0, qa}, HALF_PI_Q30));
      for (int k = ST_Y + 1; k <= ST_H_END; k++) ya[k] <= ya[k-1];

      za[ST_Z] <= q30_mul({1'b0, ya[ST_Y]}, ya[ST_Y]);
      for (int k = ST_Z + 1; k <= ST_H_END - 3; k++) za[k] <= za[k-1];

      // h = 1 - z*h/d, three stages per term
      for (int i = 0; i < TAYLOR_N; i++) begin
        xa[i] <= q30_mul(za[ST_Z + 3 * i], hin[i]);
        xb[i] <= xa[i];
        q0[i] <= 30'((64'(xa[i]) * 64'(TAYLOR_RECIP[i])) >> 32);
        hn[i] <= taylor_fix(xb[i], q0[i], TAYLOR_DIV[i]);
      end

      // Clamp the sine at one
      sprod  = ya[ST_H_END] * hn[TAYLOR_N-1];
      s_full = 32'(sprod >> 30);
      sa <= (s_full > {1'b0, Q30_ONE}) ? Q30_ONE : 31'(s_full);

      mprod = amplitude * sa;
      ma <= AMP_W'(mprod >> 30);

      // Select the factor applied to the base rate
      case (mode)
        MODE_SINE: begin
          if (period == '0) f = FX_ONE;
          else if (qd[ST_M][1]) f = (FACTOR_W'(ma) > FX_ONE) ? '0 : FX_ONE - FACTOR_W'(ma);
          else f = FX_ONE + FACTOR_W'(ma);
        end
        MODE_MULT: f = FX_ONE + FACTOR_W'(amplitude);
        MODE_ADD: begin
          if (tm[ST_M]) f = FX_ONE + FACTOR_W'(amplitude);
          else f = (FACTOR_W'(amplitude) > FX_ONE) ? '0 : FX_ONE - FACTOR_W'(amplitude);
        end
        default: f = '0;
      endcase
      fa <= f;

      pa <= base_rate * fa;
    end
  end

  // Output register: scale, saturate, pick the holiday quotient
  always_ff @(posedge clk) begin
    logic [RATE_W+FACTOR_W-FRAC_BITS-1:0] scaled;
    if (en) begin
      scaled = pa[RATE_W+FACTOR_W-1:FRAC_BITS];
      out_term   <= tm[ST_P];
      out_status <= (mode == MODE_INVALID);
      if (mode == MODE_INVALID) out_beta <= '0;
      else if (mode == MODE_MULT && !tm[ST_P]) out_beta <= hq[ST_P];
      else if (scaled > (RATE_W+FACTOR_W-FRAC_BITS)'({BETA_W{1'b1}})) out_beta <= '1;
      else out_beta <= scaled[BETA_W-1:0];
    end
  end

  assign m_axis_tvalid = v[ST_OUT];
  assign m_axis_tdata  = out_beta;
  assign m_axis_tuser  = {out_status, out_term};

endmodule

// ----- rtl/stru_checker.sv -----
module stru_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [stru_pkg::BETA_W-1:0]     m_axis_tdata,
  input logic [stru_pkg::USER_W-1:0]     m_axis_tuser
);
  import stru_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Invalid mode gives a zero rate
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("nonzero rate with error status");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // Accept input whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind seasonal_transmission_rate_unit stru_checker u_stru_checker (.*);
